@@ hdl/aft_pkg.sv @@
// shared types, constants and codes of the aabb frustum test block
package aft_pkg;

	localparam int PLANE_COUNT = 6;
	localparam int PLANE_W     = (PLANE_COUNT > 1) ? $clog2(PLANE_COUNT) : 1;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_TEST = 1'b1;

	localparam logic [1:0] VERDICT_OUTSIDE = 2'd0;
	localparam logic [1:0] VERDICT_CROSSES = 2'd1;
	localparam logic [1:0] VERDICT_INSIDE  = 2'd2;

	typedef struct packed {
		logic signed [31:0] nx;
		logic signed [31:0] ny;
		logic signed [31:0] nz;
		logic signed [31:0] off;
	} plane_t;

	typedef struct packed {
		logic               start;
		logic               issue;
		logic               last;
		logic               load_out;
		logic [PLANE_W-1:0] plane_sel;
	} ctrl_t;

	typedef struct packed {
		logic done;
	} stat_t;

endpackage

@@ hdl/aabb_frustum_test.sv @@
// top level: culls an axis-aligned box against the stored frustum planes
// a load word gives no result; a test word runs one plane per
//   cycle through two dot-product pipes (three stages) to a verdict
// a new word is accepted only after the six-plane issue loop, the drain and the output load
// the output register holds a verdict until taken while the next word is accepted
// arst_n clears the plane store to zero, the sequencer to idle and the output to empty
module aabb_frustum_test (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               cmd,
	input  logic [2:0]         plane_index,
	input  logic signed [31:0] coef_x,
	input  logic signed [31:0] coef_y,
	input  logic signed [31:0] coef_z,
	input  logic signed [31:0] offset,
	input  logic signed [31:0] min_x,
	input  logic signed [31:0] min_y,
	input  logic signed [31:0] min_z,
	input  logic signed [31:0] max_x,
	input  logic signed [31:0] max_y,
	input  logic signed [31:0] max_z,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         verdict
);
	import aft_pkg::*;

	ctrl_t  ctrl;
	stat_t  stat;
	plane_t wr_plane;
	plane_t rd_plane;
	logic   wr_en;

	// a load word with an index past the last plane is dropped
	assign wr_en = in_valid & in_ready & (cmd == CMD_LOAD)
		& ({1'b0, plane_index} < 4'(PLANE_COUNT));

	always_comb begin
		wr_plane.nx  = coef_x;
		wr_plane.ny  = coef_y;
		wr_plane.nz  = coef_z;
		wr_plane.off = offset;
	end

	// plane registers, written by load words, read by the plane counter
	aft_plane_store u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_idx   (plane_index[PLANE_W-1:0]),
		.wr_plane (wr_plane),
		.rd_idx   (ctrl.plane_sel),
		.rd_plane (rd_plane)
	);

	// sequencer: accepts words, steps planes, hands verdicts to the output
	aft_controller u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cmd       (cmd),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.ctrl      (ctrl)
	);

	// box capture, p/n vertex dot products, sign accumulation
	aft_datapath u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (ctrl),
		.stat    (stat),
		.plane   (rd_plane),
		.min_x   (min_x),
		.min_y   (min_y),
		.min_z   (min_z),
		.max_x   (max_x),
		.max_y   (max_y),
		.max_z   (max_z),
		.verdict (verdict)
	);

endmodule

@@ hdl/aft_plane_store.sv @@
// six-entry plane register file, cleared at reset, one write and one read port
module aft_plane_store (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   wr_en,
	input  logic [aft_pkg::PLANE_W-1:0] wr_idx,
	input  aft_pkg::plane_t        wr_plane,
	input  logic [aft_pkg::PLANE_W-1:0] rd_idx,
	output aft_pkg::plane_t        rd_plane
);
	import aft_pkg::*;

	plane_t planes_q [PLANE_COUNT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PLANE_COUNT; i++) begin
				planes_q[i] <= '0;
			end
		end else if (wr_en) begin
			planes_q[wr_idx] <= wr_plane;
		end
	end

	assign rd_plane = planes_q[rd_idx];

endmodule

@@ hdl/aft_datapath.sv @@
// vertex select, two dot-product pipes and verdict accumulation
module aft_datapath (
	input  logic               clk,
	input  logic               arst_n,
	input  aft_pkg::ctrl_t     ctrl,
	output aft_pkg::stat_t     stat,
	input  aft_pkg::plane_t    plane,
	input  logic signed [31:0] min_x,
	input  logic signed [31:0] min_y,
	input  logic signed [31:0] min_z,
	input  logic signed [31:0] max_x,
	input  logic signed [31:0] max_y,
	input  logic signed [31:0] max_z,
	output logic [1:0]         verdict
);
	import aft_pkg::*;

	// captured box
	logic signed [31:0] lo_x_q, lo_y_q, lo_z_q, hi_x_q, hi_y_q, hi_z_q;

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			lo_x_q <= min_x;
			lo_y_q <= min_y;
			lo_z_q <= min_z;
			hi_x_q <= max_x;
			hi_y_q <= max_y;
			hi_z_q <= max_z;
		end
	end

	// p/n vertex per axis from the normal signs
	logic               pos_x, pos_y, pos_z;
	logic signed [31:0] px, py, pz, nx, ny, nz;

	always_comb begin
		pos_x = ~plane.nx[31];
		pos_y = ~plane.ny[31];
		pos_z = ~plane.nz[31];
		px = pos_x ? hi_x_q : lo_x_q;
		py = pos_y ? hi_y_q : lo_y_q;
		pz = pos_z ? hi_z_q : lo_z_q;
		nx = pos_x ? lo_x_q : hi_x_q;
		ny = pos_y ? lo_y_q : hi_y_q;
		nz = pos_z ? lo_z_q : hi_z_q;
	end

	// stage 1: products
	logic signed [63:0] p_x_s1, p_y_s1, p_z_s1, n_x_s1, n_y_s1, n_z_s1;
	logic signed [47:0] off_s1;
	logic               valid_s1, last_s1;

	always_ff @(posedge clk) begin
		p_x_s1 <= plane.nx * px;
		p_y_s1 <= plane.ny * py;
		p_z_s1 <= plane.nz * pz;
		n_x_s1 <= plane.nx * nx;
		n_y_s1 <= plane.ny * ny;
		n_z_s1 <= plane.nz * nz;
		off_s1 <= {plane.off, 16'h0000};
		last_s1 <= ctrl.last;
	end

	// stage 2: pair sums
	logic signed [64:0] p_a_s2, p_b_s2, n_a_s2, n_b_s2;
	logic               valid_s2, last_s2;

	always_ff @(posedge clk) begin
		p_a_s2 <= {p_x_s1[63], p_x_s1} + {p_y_s1[63], p_y_s1};
		p_b_s2 <= {p_z_s1[63], p_z_s1} + {{17{off_s1[47]}}, off_s1};
		n_a_s2 <= {n_x_s1[63], n_x_s1} + {n_y_s1[63], n_y_s1};
		n_b_s2 <= {n_z_s1[63], n_z_s1} + {{17{off_s1[47]}}, off_s1};
		last_s2 <= last_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= ctrl.issue;
			valid_s2 <= valid_s1;
		end
	end

	// final sum, only the sign matters
	logic signed [65:0] p_sum, n_sum;

	always_comb begin
		p_sum = {p_a_s2[64], p_a_s2} + {p_b_s2[64], p_b_s2};
		n_sum = {n_a_s2[64], n_a_s2} + {n_b_s2[64], n_b_s2};
	end

	logic p_neg_q, n_neg_q, done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_neg_q <= 1'b0;
			n_neg_q <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= valid_s2 & last_s2;
			if (ctrl.start) begin
				p_neg_q <= 1'b0;
				n_neg_q <= 1'b0;
			end else if (valid_s2) begin
				p_neg_q <= p_neg_q | p_sum[65];
				n_neg_q <= n_neg_q | n_sum[65];
			end
		end
	end

	assign stat.done = done_q;

	// outside wins over crossing, order of planes does not matter
	logic [1:0] verdict_q;

	always_ff @(posedge clk) begin
		if (ctrl.load_out) begin
			if (p_neg_q) begin
				verdict_q <= VERDICT_OUTSIDE;
			end else if (n_neg_q) begin
				verdict_q <= VERDICT_CROSSES;
			end else begin
				verdict_q <= VERDICT_INSIDE;
			end
		end
	end

	assign verdict = verdict_q;

endmodule

@@ hdl/aft_controller.sv @@
// sequencer: plane counter, pipeline drain and output handshake
module aft_controller (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic           cmd,
	output logic           out_valid,
	input  logic           out_ready,
	input  aft_pkg::stat_t stat,
	output aft_pkg::ctrl_t ctrl
);
	import aft_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_RUN   = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_HOLD  = 4'b1000
	} state_t;

	state_t             state_q, state_d;
	logic [PLANE_W-1:0] cnt_q;
	logic               out_valid_q;
	logic               out_free;
	logic               is_last;

	assign out_free = ~out_valid_q | out_ready;
	assign is_last  = (cnt_q == PLANE_W'(PLANE_COUNT - 1));
	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d        = state_q;
		ctrl           = '0;
		ctrl.plane_sel = cnt_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid && cmd == CMD_TEST) begin
					ctrl.start = 1'b1;
					state_d    = ST_RUN;
				end
			end
			ST_RUN: begin
				ctrl.issue = 1'b1;
				ctrl.last  = is_last;
				if (is_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (stat.done) begin
					if (out_free) begin
						ctrl.load_out = 1'b1;
						state_d       = ST_IDLE;
					end else begin
						state_d = ST_HOLD;
					end
				end
			end
			ST_HOLD: begin
				if (out_free) begin
					ctrl.load_out = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctrl.start) begin
				cnt_q <= '0;
			end else if (ctrl.issue && !is_last) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (ctrl.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule
